// File: rtl/laplacian_edge_3x3_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Laplacian edge filter
// Shared concurrent assertion forms, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef LAPLACIAN_EDGE_3X3_ASSERT_SVH
`define LAPLACIAN_EDGE_3X3_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAPL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lapl_pkg.sv
// ---------------------------------------------------------------------------
// lapl_pkg
// Types, constants and the edge arithmetic of the Laplacian edge filter.
// ---------------------------------------------------------------------------
package lapl_pkg;

   // Field widths of the channel words.
   localparam int PIX_W      = 8;
   localparam int OUT_POS_W  = 10;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;

   // Default image limits and the smallest legal image side.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MIN_SIZE       = 3;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] LINE_WIDTH_RST   = CSR_DATA_W'(1024);
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RST = CSR_DATA_W'(1024);

   // Output queue sizing.
   localparam int OQ_DEPTH = 3;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_EIGHT_NB     = 2'd2
   } csr_index_type;

   // One result word.
   typedef struct packed {
      logic [PIX_W-1:0]     edge_value;
      logic [OUT_POS_W-1:0] out_row;
      logic [OUT_POS_W-1:0] out_column;
      logic                 frame_end;
   } rsp_item_type;

   // Status of the output queue.
   typedef struct packed {
      logic                empty;
      logic [OQ_CNT_W-1:0] count;
   } outq_status_type;

   // Edge value: max(0, c - clamp(c + lap, 0, 255)).
   // With four neighbors c + lap = 5c - n; with eight it is 9c - n - d.
   function automatic logic [PIX_W-1:0] edge_of(input logic [PIX_W-1:0] c,
                                                input logic [9:0] nsum4,
                                                input logic [9:0] diag4,
                                                input logic eight);
      logic signed [13:0] cs;
      logic signed [13:0] ns;
      logic signed [13:0] ds;
      logic signed [13:0] s;
      logic [PIX_W-1:0]   sc;
      cs = signed'({6'd0, c});
      ns = signed'({4'd0, nsum4});
      ds = signed'({4'd0, diag4});
      if (eight) begin
         s = cs * 14'sd9 - ns - ds;
      end else begin
         s = cs * 14'sd5 - ns;
      end
      if (s < 14'sd0) begin
         sc = '0;
      end else if (s > 14'sd255) begin
         sc = '1;
      end else begin
         sc = s[PIX_W-1:0];
      end
      return (c > sc) ? (c - sc) : '0;
   endfunction

endpackage

// File: rtl/lapl_ifs.sv
// ---------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for the pixel input and the edge result output.
// ---------------------------------------------------------------------------

// Pixel input channel.
interface lapl_req_if import lapl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// Edge result channel.
interface lapl_rsp_if import lapl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PIX_W-1:0]     edge_value;
   logic [OUT_POS_W-1:0] out_row;
   logic [OUT_POS_W-1:0] out_column;
   logic                 frame_end;

   modport source (output valid, output edge_value, output out_row, output out_column,
                   output frame_end, input ready);
   modport sink   (input valid, input edge_value, input out_row, input out_column,
                   input frame_end, output ready);
endinterface

// File: rtl/lapl_ram.sv
// ---------------------------------------------------------------------------
// lapl_ram
// Generic single-clock RAM, one write and one read port, registered read.
// A read of the address being written returns the old contents.
// ---------------------------------------------------------------------------
module lapl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Storage array and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/lapl_outq.sv
// ---------------------------------------------------------------------------
// lapl_outq
// Small output queue of result words; decouples the filter from a
// stalling receiver.
// ---------------------------------------------------------------------------
`include "laplacian_edge_3x3_assert.svh"

module lapl_outq import lapl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_item_type    push_item,
   input  logic            pop,
   output rsp_item_type    head_item,
   output outq_status_type status
);

   rsp_item_type        entries_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OQ_CNT_W-1:0] count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entries_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

   `LAPL_ASSERT_IMPL(a_no_overflow, clock, reset, push && !pop,
                     count_ff != OQ_CNT_W'(OQ_DEPTH), "push into a full output queue")
   `LAPL_ASSERT_IMPL(a_no_underflow, clock, reset, pop,
                     count_ff != '0, "pop from an empty output queue")
   `LAPL_ASSERT_IMPL(a_empty_ptrs, clock, reset, count_ff == '0,
                     rd_ptr_ff == wr_ptr_ff, "empty queue with unequal pointers")

endmodule

// File: rtl/laplacian_edge_3x3.sv
// ---------------------------------------------------------------------------
// laplacian_edge_3x3
// Streaming 3x3 Laplacian edge filter over 8-bit grayscale raster pixels.
// ---------------------------------------------------------------------------
// Pixels enter in raster order on req_ch, one word per pixel; frame_start
// marks row 0, column 0 and restarts the row and column counters. Once a
// pixel at row >= 2 and column >= 2 arrives, one result word for the
// interior pixel one row up and one column left leaves on rsp_ch, carrying
// its edge value, row, column and a frame_end flag on the frame's last
// interior pixel. Border pixels produce no word; the receiver fills them
// with zero. The csr port sets the line width, the frame height and the
// four- or eight-neighbor kernel; write it only while the block is idle.
// Throughput is one pixel per cycle while req_ch.ready is high: the line
// buffer RAM is read in the accept cycle and written back in the next
// cycle, with forwarding when the next pixel reads the entry being written.
// Result words are queued from the write-back stage; a three-word output
// queue absorbs receiver stalls, and req_ch.ready drops only when the
// queue and the pixel in flight would fill it. Reset clears the counters
// and sets the registers to 1024, 1024 and the four-neighbor kernel; the
// line buffer needs no clearing pass.
// ---------------------------------------------------------------------------
`include "laplacian_edge_3x3_assert.svh"

module laplacian_edge_3x3 import lapl_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   lapl_req_if.sink              req_ch,
   lapl_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WSW  = $clog2(MAX_WIDTH + 1);
   localparam int HSW  = $clog2(MAX_HEIGHT + 1);
   localparam int CMPW = (WSW > CSR_DATA_W) ? WSW : CSR_DATA_W;
   localparam int CMPH = (HSW > CSR_DATA_W) ? HSW : CSR_DATA_W;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] line_width_ff;
   logic [CSR_DATA_W-1:0] frame_height_ff;
   logic                  eight_nb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         eight_nb_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            CSR_EIGHT_NB:     eight_nb_ff     <= csr_wdata[0];
            default:          ;
         endcase
      end
   end

   // Image sides clamped to the legal range.
   logic [CMPW-1:0] w_cfg, w_eff;
   logic [CMPH-1:0] h_cfg, h_eff;

   always_comb begin
      w_cfg = CMPW'(line_width_ff);
      h_cfg = CMPH'(frame_height_ff);
      if (w_cfg < CMPW'(MIN_SIZE)) begin
         w_eff = CMPW'(MIN_SIZE);
      end else if (w_cfg > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = w_cfg;
      end
      if (h_cfg < CMPH'(MIN_SIZE)) begin
         h_eff = CMPH'(MIN_SIZE);
      end else if (h_cfg > CMPH'(MAX_HEIGHT)) begin
         h_eff = CMPH'(MAX_HEIGHT);
      end else begin
         h_eff = h_cfg;
      end
   end

   // Pipeline registers of the read-modify-write stage.
   logic                 s1_vld_ff;
   logic [PIX_W-1:0]     s1_pix_ff;
   logic [CW-1:0]        s1_col_ff;
   logic [RW-1:0]        s1_row_ff;
   logic                 s1_fend_ff;
   logic                 fwd_ff;
   logic [PIX_W-1:0]     fwd_top_ff;
   logic [PIX_W-1:0]     fwd_mid_ff;
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [PIX_W-1:0]     window_ff [6];

   // Output queue signals.
   rsp_item_type    q_push_item;
   rsp_item_type    q_head;
   outq_status_type q_status;
   logic            q_push;
   logic            q_pop;

   // Accept stage: counter position of the incoming pixel.
   logic          accept;
   logic [CW-1:0] col_sel;
   logic [RW-1:0] row_sel;
   logic [CW:0]   col_inc;
   logic [RW:0]   row_inc;
   logic          col_wrap;
   logic          row_wrap;
   logic          fend_sel;

   assign req_ch.ready = ({1'b0, q_status.count} + (OQ_CNT_W + 1)'(s1_vld_ff))
                         < (OQ_CNT_W + 1)'(OQ_DEPTH);
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      col_sel  = (req_ch.frame_start || (CMPW'(col_ff) >= w_eff)) ? '0 : col_ff;
      row_sel  = (req_ch.frame_start || (CMPH'(row_ff) >= h_eff)) ? '0 : row_ff;
      col_inc  = {1'b0, col_sel} + 1'b1;
      row_inc  = {1'b0, row_sel} + 1'b1;
      col_wrap = (CMPW'(col_inc) >= w_eff);
      row_wrap = (CMPH'(row_inc) >= h_eff);
      fend_sel = col_wrap && row_wrap;
      col_in   = col_wrap ? '0 : col_inc[CW-1:0];
      if (col_wrap) begin
         row_in = row_wrap ? '0 : row_inc[RW-1:0];
      end else begin
         row_in = row_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         fwd_ff    <= accept && s1_vld_ff && (s1_col_ff == col_sel);
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // Line buffer RAM: each word holds {row-2 pixel, row-1 pixel} of a column.
   logic [2*PIX_W-1:0] ram_rdata;
   logic [PIX_W-1:0]   top;
   logic [PIX_W-1:0]   mid;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_ch.pixel;
         s1_col_ff  <= col_sel;
         s1_row_ff  <= row_sel;
         s1_fend_ff <= fend_sel;
         fwd_top_ff <= mid;
         fwd_mid_ff <= s1_pix_ff;
      end
   end

   lapl_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (s1_vld_ff),
      .waddr (s1_col_ff),
      .wdata ({mid, s1_pix_ff}),
      .re    (accept),
      .raddr (col_sel),
      .rdata (ram_rdata)
   );

   // Column read back from the RAM, or forwarded from the previous pixel.
   always_comb begin
      if (fwd_ff) begin
         top = fwd_top_ff;
         mid = fwd_mid_ff;
      end else begin
         top = ram_rdata[2*PIX_W-1:PIX_W];
         mid = ram_rdata[PIX_W-1:0];
      end
   end

   // Window shift: entries 0..2 hold column col-2, entries 3..5 column col-1.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= '0;
         end
      end else if (s1_vld_ff) begin
         window_ff[0] <= window_ff[3];
         window_ff[1] <= window_ff[4];
         window_ff[2] <= window_ff[5];
         window_ff[3] <= top;
         window_ff[4] <= mid;
         window_ff[5] <= s1_pix_ff;
      end
   end

   // Stencil sums and the result word of an interior pixel.
   logic [9:0] nsum4;
   logic [9:0] diag4;

   assign nsum4 = 10'(window_ff[3]) + 10'(window_ff[5]) + 10'(window_ff[1]) + 10'(mid);
   assign diag4 = 10'(window_ff[0]) + 10'(window_ff[2]) + 10'(top) + 10'(s1_pix_ff);

   assign q_push = s1_vld_ff && (s1_row_ff >= RW'(2)) && (s1_col_ff >= CW'(2));
   assign q_push_item.edge_value = edge_of(window_ff[4], nsum4, diag4, eight_nb_ff);
   assign q_push_item.out_row    = OUT_POS_W'(s1_row_ff - 1'b1);
   assign q_push_item.out_column = OUT_POS_W'(s1_col_ff - 1'b1);
   assign q_push_item.frame_end  = s1_fend_ff;

   lapl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head),
      .status    (q_status)
   );

   // Result channel driven from the queue head.
   assign rsp_ch.valid      = !q_status.empty;
   assign rsp_ch.edge_value = q_head.edge_value;
   assign rsp_ch.out_row    = q_head.out_row;
   assign rsp_ch.out_column = q_head.out_column;
   assign rsp_ch.frame_end  = q_head.frame_end;
   assign q_pop             = rsp_ch.valid && rsp_ch.ready;

   `LAPL_ASSERT_NEXT(a_accept_stage, clock, reset, accept,
                     s1_vld_ff, "accepted pixel did not reach the write-back stage")
   `LAPL_ASSERT_IMPL(a_col_in_line, clock, reset, s1_vld_ff,
                     CMPW'(s1_col_ff) < w_eff, "column beyond the line width")
   `LAPL_ASSERT_IMPL(a_fwd_live, clock, reset, fwd_ff,
                     s1_vld_ff, "forwarded column without a pixel in flight")
   `LAPL_ASSERT_IMPL(a_rsp_interior, clock, reset, rsp_ch.valid,
                     (rsp_ch.out_row != '0) && (rsp_ch.out_column != '0),
                     "result word for a border pixel")

endmodule
